@@ rtl/sqaf_pkg.sv @@
// Shared types and constants for the sequence aligned FIFO.
package sqaf_pkg;

	// Store geometry
	localparam int DEPTH = 64;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int SEQ_W = 32;
	localparam int TAG_W = 32;
	localparam int CFG_W = 7;
	localparam int IDX_W = 2;

	// Counter distance beyond which a larger front counter counts as wrapped
	localparam logic [SEQ_W-1:0] WRAP_SPAN = SEQ_W'(32'h0001_0000);

	// Opcodes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_ALIGN = 2'd1;
	localparam logic [1:0] OP_POP   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] CFG_MAX_ENTRIES = IDX_W'(0);
	localparam logic [IDX_W-1:0] CFG_ENABLE      = IDX_W'(1);

	// Reset values of the configuration registers
	localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(DEPTH);

	typedef struct packed {
		logic [1:0]       opcode;
		logic [SEQ_W-1:0] seq_count;
		logic [TAG_W-1:0] payload_tag;
	} in_item_t;

	typedef struct packed {
		logic             matched;
		logic [CNT_W-1:0] entry_count;
		logic [SEQ_W-1:0] front_seq;
		logic [TAG_W-1:0] front_tag;
		logic [CNT_W-1:0] dropped;
	} out_item_t;

	// One stored entry
	typedef struct packed {
		logic [SEQ_W-1:0] seq_count;
		logic [TAG_W-1:0] payload_tag;
	} entry_t;

	// Request from the sequencer to the entry store
	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		entry_t           wdata;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

endpackage

@@ rtl/sqaf_mem.sv @@
// Entry store: one write port, one registered read port.
module sqaf_mem (
	input  logic              clk,
	input  sqaf_pkg::mem_req_t req,
	output sqaf_pkg::entry_t   rdata
);
	import sqaf_pkg::*;

	entry_t mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[req.raddr];
	end

endmodule

@@ rtl/sqaf_ctrl.sv @@
// Sequencer: pointers, configuration, opcode execution and the front compare loop.
module sqaf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sqaf_pkg::in_item_t        in_data,
	input  logic                      cfg_we,
	input  logic [sqaf_pkg::IDX_W-1:0] cfg_idx,
	input  logic [sqaf_pkg::CFG_W-1:0] cfg_wdata,
	output sqaf_pkg::mem_req_t        mem_req,
	input  sqaf_pkg::entry_t          mem_rdata,
	output logic                      res_valid,
	input  logic                      res_ready,
	output sqaf_pkg::out_item_t       res
);
	import sqaf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_RD   = 4'b0100,
		ST_CHK  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] max_q;
	logic             en_q;
	logic [CNT_W-1:0] drop_q;

	// Captured transaction
	logic [1:0]       op_q;
	logic [SEQ_W-1:0] seq_q;
	logic [TAG_W-1:0] tag_q;

	logic [CNT_W-1:0] lim;
	logic             full;
	logic [PTR_W-1:0] h1;
	logic [CNT_W-1:0] c1;
	logic [CNT_W-1:0] c2;
	logic [PTR_W-1:0] slot;
	logic [CNT_W-1:0] excess;
	logic [CNT_W-1:0] cfg_lim;
	logic [CNT_W-1:0] trim_excess;
	logic             not_empty;
	logic             older;
	logic             align_drop;
	logic             done;

	// Effective limit, saturated at the store depth
	assign lim = (max_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_q;

	// Push arithmetic: drop one when full, append, then trim to the limit
	always_comb begin
		full   = (held_q == CNT_W'(DEPTH));
		h1     = full ? head_q + PTR_W'(1) : head_q;
		c1     = full ? held_q - CNT_W'(1) : held_q;
		slot   = h1 + c1[PTR_W-1:0];
		c2     = c1 + CNT_W'(1);
		excess = (c2 > lim) ? c2 - lim : '0;
	end

	// Trim amount for a limit write
	always_comb begin
		cfg_lim     = (cfg_wdata > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_wdata;
		trim_excess = (held_q > cfg_lim) ? held_q - cfg_lim : '0;
	end

	// Shared front compare: is the front counter older than the target
	assign not_empty  = (held_q != '0);
	assign older      = (seq_q > mem_rdata.seq_count)
		|| ((seq_q < mem_rdata.seq_count)
		&& ((mem_rdata.seq_count - seq_q) > WRAP_SPAN));
	assign align_drop = (op_q == OP_ALIGN) && not_empty && older;
	assign done       = (state_q == ST_CHK) && !align_drop;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = done;

	// Store access
	always_comb begin
		mem_req.we    = (state_q == ST_EXEC) && (op_q == OP_PUSH) && en_q;
		mem_req.waddr = slot;
		mem_req.wdata = '{seq_count: seq_q, payload_tag: tag_q};
		mem_req.raddr = head_q;
	end

	// Result assembly
	always_comb begin
		res.matched     = (op_q == OP_ALIGN) && not_empty
			&& (mem_rdata.seq_count == seq_q);
		res.entry_count = held_q;
		res.front_seq   = not_empty ? mem_rdata.seq_count : '0;
		res.front_tag   = not_empty ? mem_rdata.payload_tag : '0;
		res.dropped     = drop_q;
	end

	// Transaction capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= in_data.opcode;
			seq_q <= in_data.seq_count;
			tag_q <= in_data.payload_tag;
		end
	end

	// Sequencer and store pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			held_q  <= '0;
			max_q   <= MAX_ENTRIES_RST;
			en_q    <= 1'b1;
			drop_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we && (cfg_idx == CFG_MAX_ENTRIES)) begin
						max_q  <= cfg_wdata;
						head_q <= head_q + trim_excess[PTR_W-1:0];
						held_q <= held_q - trim_excess;
					end else if (cfg_we && (cfg_idx == CFG_ENABLE)) begin
						en_q   <= cfg_wdata[0];
						head_q <= '0;
						held_q <= '0;
					end
					if (in_valid) begin
						drop_q  <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (op_q)
						OP_PUSH: begin
							if (en_q) begin
								head_q <= h1 + excess[PTR_W-1:0];
								held_q <= c2 - excess;
								drop_q <= excess + CNT_W'(full);
							end
						end
						OP_ALIGN: begin
						end
						OP_POP: begin
							if (not_empty) begin
								head_q <= head_q + PTR_W'(1);
								held_q <= held_q - CNT_W'(1);
								drop_q <= CNT_W'(1);
							end
						end
						OP_CLEAR: begin
							drop_q <= held_q;
							head_q <= '0;
							held_q <= '0;
						end
						default: begin
						end
					endcase
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (align_drop) begin
						head_q  <= head_q + PTR_W'(1);
						held_q  <= held_q - CNT_W'(1);
						drop_q  <= drop_q + CNT_W'(1);
						state_q <= ST_RD;
					end else if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/sequence_aligned_fifo.sv @@
// Sequence aligned FIFO: top level with result register.
// An accepted transaction steps through the EXEC, RD and CHK states, then its result is
// registered in the output register; an align loops from CHK back to RD for each entry it drops.
// Transactions are taken one at a time, only while the sequencer is idle, since the single store
// read port and the shared front compare handle one entry at a time.
// The next transaction is taken while a finished result still waits in the output register.
// Reset empties the store at once (contents undefined until written), limit 64, pushes enabled.
module sequence_aligned_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  sqaf_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sqaf_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [sqaf_pkg::IDX_W-1:0] cfg_idx,
	input  logic [sqaf_pkg::CFG_W-1:0] cfg_wdata
);
	import sqaf_pkg::*;

	mem_req_t  mem_req;
	entry_t    mem_rdata;
	logic      res_valid;
	logic      res_ready;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_data_q;

	sqaf_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	sqaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output slot is free when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ tb/sqaf_checker.sv @@
// Result checker for the sequence aligned FIFO: shadow store, prediction and comparison.
`timescale 1ns / 100ps

module sqaf_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  sqaf_pkg::in_item_t         in_data,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  sqaf_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [sqaf_pkg::IDX_W-1:0] cfg_idx,
	input  logic [sqaf_pkg::CFG_W-1:0] cfg_wdata,
	output int                         mismatch_count,
	output int                         pending_results,
	output int                         checked_count
);
	import sqaf_pkg::*;

	// Shadow copy of the store and its registers
	logic [SEQ_W-1:0] seq_mem [DEPTH];
	logic [TAG_W-1:0] tag_mem [DEPTH];
	int unsigned      head_idx;
	int unsigned      held;
	logic [CFG_W-1:0] limit_reg;
	logic             enable_reg;

	// Results still owed by the block, oldest first
	out_item_t        awaited_results [$];
	out_item_t        oldest;
	out_item_t        predicted;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void retire_front();
		if (held != 0) begin
			head_idx = (head_idx + 1) % DEPTH;
			held--;
		end
	endfunction

	// Drop from the front until the store is within the effective limit
	function automatic int unsigned trim_to_cap();
		int unsigned cap;
		int unsigned n;
		cap = (limit_reg > DEPTH) ? DEPTH : limit_reg;
		n = 0;
		while (held > cap) begin
			retire_front();
			n++;
		end
		return n;
	endfunction

	// Apply one transaction to the shadow store and describe the store afterwards
	function automatic out_item_t store_after_item(input in_item_t item);
		out_item_t        res;
		int unsigned      lost;
		int unsigned      slot;
		logic [SEQ_W-1:0] f;
		logic             older;
		res  = '0;
		lost = 0;
		case (item.opcode)
			OP_PUSH: begin
				if (enable_reg) begin
					if (held >= DEPTH) begin
						retire_front();
						lost++;
					end
					slot = (head_idx + held) % DEPTH;
					seq_mem[slot] = item.seq_count;
					tag_mem[slot] = item.payload_tag;
					held++;
					lost += trim_to_cap();
				end
			end
			OP_ALIGN: begin
				older = 1'b1;
				while (held != 0 && older) begin
					f = seq_mem[head_idx];
					// behind the target, or so far ahead that the counter must have wrapped
					older = (item.seq_count > f) ||
						(item.seq_count < f && (f - item.seq_count) > WRAP_SPAN);
					if (older) begin
						retire_front();
						lost++;
					end
				end
				res.matched = (held != 0) && (seq_mem[head_idx] == item.seq_count);
			end
			OP_POP: begin
				if (held != 0) begin
					retire_front();
					lost = 1;
				end
			end
			OP_CLEAR: begin
				lost     = held;
				head_idx = 0;
				held     = 0;
			end
			default: ;
		endcase
		if (held != 0) begin
			res.front_seq = seq_mem[head_idx];
			res.front_tag = tag_mem[head_idx];
		end
		res.entry_count = CNT_W'(held);
		res.dropped     = CNT_W'(lost);
		return res;
	endfunction

	// Watch configuration, results and accepted transactions at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx        = 0;
			held            = 0;
			limit_reg       = MAX_ENTRIES_RST;
			enable_reg      = 1'b1;
			awaited_results.delete();
			pending_results = 0;
			checked_count   = 0;
			mismatch_count  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MAX_ENTRIES: begin
						limit_reg = cfg_wdata;
						void'(trim_to_cap());
					end
					CFG_ENABLE: begin
						enable_reg = cfg_wdata[0];
						head_idx   = 0;
						held       = 0;
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result arrived with nothing awaited");
				end else begin
					oldest = awaited_results[0];
					awaited_results.delete(0);
					checked_count++;
					if (out_data.matched !== oldest.matched)
						report_mismatch($sformatf("matched: got %0b, want %0b",
							out_data.matched, oldest.matched));
					if (out_data.entry_count !== oldest.entry_count)
						report_mismatch($sformatf("entry_count: got %0d, want %0d",
							out_data.entry_count, oldest.entry_count));
					if (out_data.front_seq !== oldest.front_seq)
						report_mismatch($sformatf("front_seq: got %h, want %h",
							out_data.front_seq, oldest.front_seq));
					if (out_data.front_tag !== oldest.front_tag)
						report_mismatch($sformatf("front_tag: got %h, want %h",
							out_data.front_tag, oldest.front_tag));
					if (out_data.dropped !== oldest.dropped)
						report_mismatch($sformatf("dropped: got %0d, want %0d",
							out_data.dropped, oldest.dropped));
				end
			end
			if (in_valid && in_ready) begin
				predicted       = store_after_item(in_data);
				awaited_results = {awaited_results, predicted};
			end
			pending_results = awaited_results.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the sequence aligned FIFO testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
	import sqaf_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 10;
	localparam int HOLD_OFF_CYCLES = 300;

	// Register indexes the block has no register behind
	localparam logic [IDX_W-1:0] CFG_SPARE_LO = IDX_W'(2);
	localparam logic [IDX_W-1:0] CFG_SPARE_HI = IDX_W'(3);

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_ready;
	out_item_t         out_data;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_idx;
	logic [CFG_W-1:0]  cfg_wdata;

	int                mismatch_count;
	int                pending_results;
	int                checked_count;
	int                cycle_count = 0;
	int                sender_idle_pct = 32;
	int                receiver_idle_pct = 77;
	bit                hold_off_req = 1'b0;
	int                op_count [4] = '{default: 0};
	int                cfg_writes = 0;
	logic [SEQ_W-1:0]  seq_cursor;

	sequence_aligned_fifo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	sqaf_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results),
		.checked_count   (checked_count)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Result side: random back-pressure, or a long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready    <= 1'b0;
				hold_off_req  = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
			end
		end
	end

	function automatic in_item_t make_item(input logic [1:0] op, input logic [SEQ_W-1:0] seq,
		input logic [TAG_W-1:0] tag);
		in_item_t item;
		item.opcode      = op;
		item.seq_count   = seq;
		item.payload_tag = tag;
		return item;
	endfunction

	// Mostly ordered counters so aligns land near live entries; some noise
	function automatic in_item_t random_item(input int unsigned push_pct);
		in_item_t    item;
		int unsigned pick;
		item.payload_tag = $urandom();
		item.seq_count   = $urandom();
		if ($urandom_range(99, 0) < push_pct) begin
			item.opcode = OP_PUSH;
			if ($urandom_range(99, 0) < 92) begin
				seq_cursor     = seq_cursor + $urandom_range(3, 1);
				item.seq_count = seq_cursor;
			end
		end else begin
			pick = $urandom_range(99, 0);
			if (pick < 60) begin
				item.opcode = OP_ALIGN;
				pick = $urandom_range(9, 0);
				if (pick < 5)
					item.seq_count = seq_cursor - $urandom_range(30, 0);
				else if (pick < 7)
					item.seq_count = seq_cursor + $urandom_range(5, 1);
				else if (pick < 8)
					// around the wrap distance from recent fronts
					item.seq_count = seq_cursor - WRAP_SPAN - $urandom_range(4, 0)
						+ $urandom_range(40, 0);
				else if (pick < 9)
					item.seq_count = seq_cursor;
			end else if (pick < 92) begin
				item.opcode = OP_POP;
			end else begin
				item.opcode = OP_CLEAR;
			end
		end
		return item;
	endfunction

	// Offer one transaction, with random idle cycles first, and wait for its acceptance
	task automatic send_item(input in_item_t item);
		@(negedge clk);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		op_count[item.opcode]++;
	endtask

	task automatic run_random(input int count, input int unsigned push_pct);
		repeat (count) send_item(random_item(push_pct));
	endtask

	// Stop offering and let every owed result drain
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_writes++;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty store, wrap distance edges, matches
		send_item(make_item(OP_POP,   32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_ALIGN, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_PUSH,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(OP_PUSH,  32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_ALIGN, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_CLEAR, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_PUSH,  32'h0001_0000, 32'h5A5A_5A5A));
		send_item(make_item(OP_ALIGN, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_PUSH,  32'h0001_0001, 32'hA5A5_A5A5));
		send_item(make_item(OP_POP,   32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_ALIGN, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(OP_PUSH,  32'h8000_0000, 32'h1234_5678));
		send_item(make_item(OP_PUSH,  32'h8000_0005, 32'h8765_4321));
		send_item(make_item(OP_ALIGN, 32'h8000_0003, 32'h0000_0000));
		send_item(make_item(OP_POP,   32'h0000_0000, 32'h0000_0000));

		// Directed: zero limit drops the new entry straight away
		settle_block();
		write_register(CFG_MAX_ENTRIES, CFG_W'(0));
		send_item(make_item(OP_PUSH, 32'h0000_0007, 32'h0000_0007));

		// Directed: small limit trims on push, then a lower limit trims silently
		settle_block();
		write_register(CFG_MAX_ENTRIES, CFG_W'(3));
		send_item(make_item(OP_PUSH, 32'h0000_0010, 32'hC000_0001));
		send_item(make_item(OP_PUSH, 32'h0000_0011, 32'hC000_0002));
		send_item(make_item(OP_PUSH, 32'h0000_0012, 32'hC000_0003));
		send_item(make_item(OP_PUSH, 32'h0000_0013, 32'hC000_0004));
		settle_block();
		write_register(CFG_MAX_ENTRIES, CFG_W'(1));
		send_item(make_item(OP_POP, 32'h0000_0000, 32'h0000_0000));

		// Directed: disabled pushes; writes to unused indexes change nothing
		settle_block();
		write_register(CFG_ENABLE, CFG_W'(0));
		send_item(make_item(OP_PUSH, 32'h0000_0020, 32'h0000_0020));
		settle_block();
		write_register(CFG_SPARE_LO, CFG_W'(7'h7F));
		write_register(CFG_SPARE_HI, CFG_W'(7'h7F));
		send_item(make_item(OP_PUSH, 32'h0000_0021, 32'h0000_0021));
		settle_block();
		write_register(CFG_ENABLE, CFG_W'(1));
		write_register(CFG_MAX_ENTRIES, CFG_W'(7'h7F));
		send_item(make_item(OP_PUSH,  32'h0000_0022, 32'h0000_0022));
		send_item(make_item(OP_CLEAR, 32'h0000_0000, 32'h0000_0000));

		// Random, full depth: fill past DEPTH first so full-store pushes occur
		seq_cursor = $urandom();
		settle_block();
		write_register(CFG_MAX_ENTRIES, CFG_W'(DEPTH));
		write_register(CFG_ENABLE, CFG_W'(1));
		run_random(70, 100);
		run_random(280, 55);

		// Random, saturating limit, receiver mostly ready; long output hold-off first
		settle_block();
		sender_idle_pct   = 77;
		receiver_idle_pct = 32;
		write_register(CFG_MAX_ENTRIES, CFG_W'(7'h7F));
		hold_off_req = 1'b1;
		run_random(200, 60);
		settle_block();
		run_random(150, 55);

		// Back to back from here on
		settle_block();
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		write_register(CFG_MAX_ENTRIES, CFG_W'(5));
		run_random(300, 50);

		settle_block();
		write_register(CFG_MAX_ENTRIES, CFG_W'(0));
		run_random(40, 60);

		settle_block();
		write_register(CFG_MAX_ENTRIES, CFG_W'(20));
		write_register(CFG_ENABLE, CFG_W'(0));
		run_random(40, 60);

		// Counters crossing the 32-bit wrap
		settle_block();
		write_register(CFG_ENABLE, CFG_W'(1));
		write_register(CFG_MAX_ENTRIES, CFG_W'(40));
		seq_cursor = 32'hFFFF_FFA0;
		run_random(180, 55);

		settle_block();
		$display("Run covered %0d pushes, %0d aligns, %0d pops, %0d clears, %0d register writes",
			op_count[OP_PUSH], op_count[OP_ALIGN], op_count[OP_POP], op_count[OP_CLEAR],
			cfg_writes);
		$display("%0d results compared over %0d cycles, %0d mismatches",
			checked_count, cycle_count, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
